// File: design/ldr_pkg.sv
// Shared types, register indexes and small functions for the LED dice roll controller.
package ldr_pkg;

    // Phase of the roll, as reported on the result port
    typedef enum logic [2:0] {
        PH_SLEEP = 3'd0,
        PH_QUICK = 3'd1,
        PH_SLOW  = 3'd2,
        PH_BLINK = 3'd3,
        PH_HOLD  = 3'd4
    } ldr_phase_t;

    // Per-tick sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_DRAW,
        S_SLOW_ADV,
        S_SQ,
        S_DIV,
        S_MUL,
        S_DONE
    } ldr_seq_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_SHORT_PRESS  = 3'd0;
    localparam logic [2:0] CFG_QUICK_PERIOD = 3'd1;
    localparam logic [2:0] CFG_LONG_PRESS   = 3'd2;
    localparam logic [2:0] CFG_SLOW_STEPS   = 3'd3;
    localparam logic [2:0] CFG_SLOW_UNIT    = 3'd4;
    localparam logic [2:0] CFG_BLINK_COUNT  = 3'd5;
    localparam logic [2:0] CFG_BLINK_HALF   = 3'd6;
    localparam logic [2:0] CFG_HOLD         = 3'd7;

    // floor(x/10) for x < 4096 as (x * 3277) >> 15
    localparam logic [11:0] DIV10_RECIP = 12'd3277;
    localparam int          DIV10_SHIFT = 15;

    // One xorshift step, shifts 5, 3, 6
    function automatic logic [7:0] xorshift8(input logic [7:0] x);
        logic [7:0] t;
        t = x ^ (x << 5);
        t = t ^ (t >> 3);
        t = t ^ (t << 6);
        return t;
    endfunction

    // v mod 6 via reciprocal: q = (v * 171) >> 10 is exact for v < 256
    function automatic logic [2:0] mod6(input logic [7:0] v);
        logic [15:0] p;
        logic [5:0]  q;
        logic [7:0]  m;
        p = 16'(v) * 16'd171;
        q = p[15:10];
        m = v - {1'b0, q, 1'b0} - {q, 2'b00};
        return m[2:0];
    endfunction

    // LED port bits for each face
    function automatic logic [7:0] face_leds(input logic [2:0] f);
        logic [7:0] r;
        case (f)
            3'd0:    r = 8'h08;
            3'd1:    r = 8'h84;
            3'd2:    r = 8'h8C;
            3'd3:    r = 8'hC5;
            3'd4:    r = 8'hCD;
            3'd5:    r = 8'hE7;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// File: design/ldr_prng.sv
// Shared xorshift generator with redraw loop: steps until the face changes or the step limit is reached.
module ldr_prng import ldr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    output logic       done,
    output logic [2:0] face
);

    logic [7:0] value_reg, value_next;
    logic [2:0] last_reg, last_next;
    logic [7:0] cnt_reg, cnt_next;
    logic       run_reg, run_next;
    logic       redraw;

    assign face   = mod6(value_reg);
    // keep stepping while the face matches the old one, at most 255 steps
    assign redraw = (face == last_reg) && (cnt_reg != 8'hFF);
    assign done   = run_reg && !redraw;

    always_comb begin
        value_next = value_reg;
        last_next  = last_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        if (start) begin
            last_next = face;
            cnt_next  = 8'd0;
            run_next  = 1'b1;
        end else if (run_reg) begin
            if (redraw) begin
                value_next = xorshift8(value_reg);
                cnt_next   = cnt_reg + 8'd1;
            end else begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= 8'd1;
            run_reg   <= 1'b0;
        end else begin
            value_reg <= value_next;
            run_reg   <= run_next;
        end
        last_reg <= last_next;
        cnt_reg  <= cnt_next;
    end

endmodule

// File: design/led_dice_roll_controller_top.sv
// Top level of the LED dice roll controller: tick sequencer, config registers, result register.
// Each tick item passes idle, dispatch and done; a draw adds the generator's redraw steps,
//   a slowing step adds advance, square, divide and multiply; zero-wait chains add up.
// Throughput: one item at a time; the next tick is taken once the sequencer is back in idle,
//   even while the previous result still waits in the output register.
// Reset: synchronous, active-low aresetn; config to defaults, sleep, generator 1, counters 0.
module led_dice_roll_controller_top import ldr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // tick input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_button_pressed,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_led_pattern,
    output logic [2:0]  m_die_face,
    output logic [2:0]  m_phase,
    // config write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    // ---------------- configuration registers ----------------
    logic [15:0] short_press_reg;
    logic [7:0]  quick_period_reg;
    logic [15:0] long_press_reg;
    logic [5:0]  slow_steps_reg;
    logic [3:0]  slow_unit_reg;
    logic [7:0]  blink_count_reg;
    logic [9:0]  blink_half_reg;
    logic [15:0] hold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_press_reg  <= 16'd200;
            quick_period_reg <= 8'd25;
            long_press_reg   <= 16'd10000;
            slow_steps_reg   <= 6'd27;
            slow_unit_reg    <= 4'd2;
            blink_count_reg  <= 8'd6;
            blink_half_reg   <= 10'd100;
            hold_reg         <= 16'd10000;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SHORT_PRESS:  short_press_reg  <= cfg_wdata;
                CFG_QUICK_PERIOD: quick_period_reg <= cfg_wdata[7:0];
                CFG_LONG_PRESS:   long_press_reg   <= cfg_wdata;
                CFG_SLOW_STEPS:   slow_steps_reg   <= cfg_wdata[5:0];
                CFG_SLOW_UNIT:    slow_unit_reg    <= cfg_wdata[3:0];
                CFG_BLINK_COUNT:  blink_count_reg  <= cfg_wdata[7:0];
                CFG_BLINK_HALF:   blink_half_reg   <= cfg_wdata[9:0];
                CFG_HOLD:         hold_reg         <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- roll state ----------------
    ldr_seq_t    state_reg, state_next;
    ldr_phase_t  phase_reg, phase_next;
    logic [15:0] press_reg, press_next;
    logic [15:0] wait_reg, wait_next;
    logic [8:0]  step_reg, step_next;
    logic        await_reg, await_next;
    logic        btn_reg, btn_next;

    // slowing wait pipeline: i*i, then /10, then * unit
    logic [11:0] sq_reg, sq_next;
    logic [8:0]  div_reg, div_next;

    // result register
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  led_reg, led_next;
    logic [2:0]  face_reg, face_next;
    logic [2:0]  phase_out_reg, phase_out_next;

    // generator
    logic        draw_start;
    logic        draw_done;
    logic [2:0]  face;

    ldr_prng u_prng (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (draw_start),
        .done    (draw_done),
        .face    (face)
    );

    // ---------------- shared decision terms ----------------
    logic [7:0]  quick_per;      // zero period reads as 1
    logic [9:0]  blink_half;     // zero half reads as 1
    logic [15:0] wait_dec;
    logic        wait_zero;
    logic [9:0]  step_inc;
    logic        slow_end;
    logic        blink_end;
    logic        press_over;
    logic        press_short;
    logic [16:0] press_sum;
    logic [15:0] press_sat;
    logic [23:0] div_prod;
    logic [12:0] mul_val;

    assign quick_per   = (quick_period_reg == 8'd0) ? 8'd1 : quick_period_reg;
    assign blink_half  = (blink_half_reg == 10'd0) ? 10'd1 : blink_half_reg;
    assign wait_dec    = (wait_reg == 16'd0) ? 16'd0 : wait_reg - 16'd1;
    assign wait_zero   = (wait_dec == 16'd0);
    assign step_inc    = {1'b0, step_reg} + 10'd1;
    assign slow_end    = step_inc > {4'd0, slow_steps_reg};
    assign blink_end   = step_inc >= {1'b0, blink_count_reg, 1'b0};
    assign press_over  = press_reg > long_press_reg;
    assign press_short = press_reg <= short_press_reg;
    assign press_sum   = {1'b0, press_reg} + {9'd0, quick_per};
    assign press_sat   = press_sum[16] ? 16'hFFFF : press_sum[15:0];
    assign div_prod    = {12'd0, sq_reg} * {12'd0, DIV10_RECIP};
    assign mul_val     = {4'd0, div_reg} * {9'd0, slow_unit_reg};

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_led_pattern = led_reg;
    assign m_die_face    = face_reg;
    assign m_phase       = phase_out_reg;

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (phase_reg)
                    PH_QUICK: begin
                        if (!wait_zero || press_over) state_next = S_DONE;
                        else if (btn_reg)             state_next = S_DRAW;
                        else if (press_short)         state_next = S_DONE;
                        else                          state_next = S_SLOW_ADV;
                    end
                    PH_SLOW, PH_BLINK, PH_HOLD: begin
                        if (btn_reg)                   state_next = S_DRAW;
                        else if (!wait_zero)           state_next = S_DONE;
                        else if (phase_reg == PH_SLOW) state_next = S_SLOW_ADV;
                        else                           state_next = S_DONE;
                    end
                    default: begin
                        if (!await_reg && btn_reg) state_next = S_DRAW;
                        else                       state_next = S_DONE;
                    end
                endcase
            end
            S_DRAW: begin
                // a slowing draw goes on to work out its wait
                if (draw_done) state_next = (phase_reg == PH_SLOW) ? S_SQ : S_DONE;
            end
            S_SLOW_ADV: state_next = slow_end ? S_DONE : S_DRAW;
            S_SQ:       state_next = S_DIV;
            S_DIV:      state_next = S_MUL;
            S_MUL:      state_next = (mul_val != 13'd0) ? S_DONE : S_SLOW_ADV;
            S_DONE: begin
                if (!m_valid_reg || m_ready) state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb begin
        phase_next     = phase_reg;
        press_next     = press_reg;
        wait_next      = wait_reg;
        step_next      = step_reg;
        await_next     = await_reg;
        btn_next       = btn_reg;
        sq_next        = sq_reg;
        div_next       = div_reg;
        draw_start     = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;
        led_next       = led_reg;
        face_next      = face_reg;
        phase_out_next = phase_out_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) btn_next = s_button_pressed;
            end
            S_DISPATCH: begin
                case (phase_reg)
                    PH_QUICK: begin
                        wait_next = wait_dec;
                        if (wait_zero) begin
                            if (press_over) begin
                                phase_next = PH_SLEEP;
                                await_next = 1'b1;
                            end else if (btn_reg) begin
                                draw_start = 1'b1;
                                press_next = press_sat;
                                wait_next  = {8'd0, quick_per};
                            end else if (press_short) begin
                                phase_next = PH_SLEEP;
                            end else begin
                                phase_next = PH_SLOW;
                                step_next  = 9'd0;
                            end
                        end
                    end
                    PH_SLOW, PH_BLINK, PH_HOLD: begin
                        if (btn_reg) begin
                            // any press restarts quick cycling
                            phase_next = PH_QUICK;
                            draw_start = 1'b1;
                            press_next = {8'd0, quick_per};
                            wait_next  = {8'd0, quick_per};
                        end else begin
                            wait_next = wait_dec;
                            if (wait_zero) begin
                                if (phase_reg == PH_BLINK) begin
                                    step_next = step_inc[8:0];
                                    if (blink_end) begin
                                        if (hold_reg == 16'd0) begin
                                            phase_next = PH_SLEEP;
                                        end else begin
                                            phase_next = PH_HOLD;
                                            wait_next  = hold_reg;
                                        end
                                    end else begin
                                        wait_next = {6'd0, blink_half};
                                    end
                                end else if (phase_reg == PH_HOLD) begin
                                    phase_next = PH_SLEEP;
                                end
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_SLEEP;
                        if (await_reg) begin
                            if (!btn_reg) await_next = 1'b0;
                        end else if (btn_reg) begin
                            phase_next = PH_QUICK;
                            draw_start = 1'b1;
                            press_next = {8'd0, quick_per};
                            wait_next  = {8'd0, quick_per};
                        end
                    end
                endcase
            end
            S_SLOW_ADV: begin
                if (slow_end) begin
                    // slowing done: blink, or hold, or sleep when both are zero length
                    if (blink_count_reg != 8'd0) begin
                        phase_next = PH_BLINK;
                        step_next  = 9'd0;
                        wait_next  = {6'd0, blink_half};
                    end else if (hold_reg != 16'd0) begin
                        phase_next = PH_HOLD;
                        wait_next  = hold_reg;
                    end else begin
                        phase_next = PH_SLEEP;
                    end
                end else begin
                    step_next  = step_inc[8:0];
                    draw_start = 1'b1;
                end
            end
            S_SQ: begin
                // slowing step index is at most 63 here
                sq_next = {6'd0, step_reg[5:0]} * {6'd0, step_reg[5:0]};
            end
            S_DIV: begin
                div_next = div_prod[DIV10_SHIFT +: 9];
            end
            S_MUL: begin
                wait_next = {3'd0, mul_val};
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    face_next      = face;
                    phase_out_next = phase_reg;
                    // dark in sleep and in the off halves of the blink
                    if (phase_reg == PH_SLEEP || (phase_reg == PH_BLINK && !step_reg[0]))
                        led_next = 8'h00;
                    else
                        led_next = face_leds(face);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_SLEEP;
            press_reg   <= 16'd0;
            wait_reg    <= 16'd0;
            step_reg    <= 9'd0;
            await_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            press_reg   <= press_next;
            wait_reg    <= wait_next;
            step_reg    <= step_next;
            await_reg   <= await_next;
            m_valid_reg <= m_valid_next;
        end
        btn_reg       <= btn_next;
        sq_reg        <= sq_next;
        div_reg       <= div_next;
        led_reg       <= led_next;
        face_reg      <= face_next;
        phase_out_reg <= phase_out_next;
    end

endmodule
